// ===== rtl/rplb_pkg.sv =====
// Package for the record prefix to line break filter.
// Holds the front state encoding, the queue entry type and byte constants.
// No dependencies.
`default_nettype none

package rplb_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 4;

   localparam logic [15:0] SIZE_LIMIT_RST = 16'd8192;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic CSR_ENABLE     = 1'b0;
   localparam logic CSR_SIZE_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      PH_LOW  = 3'd0,
      PH_HIGH = 3'd1,
      PH_DATA = 3'd2,
      PH_PAD  = 3'd3,
      PH_PASS = 3'd4
   } phase_type;

   typedef struct packed {
      logic       two;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       pt;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/record_prefix_to_line_break_filter_unit.sv =====
// Top level of the record prefix to line break filter.
// Instantiates rplb_front, rplb_queue and rplb_back; depends on rplb_pkg.
//
// Usage:
//   Input bytes enter on req_data_byte, taken at an edge with req_push high and
//   req_full low. Results leave as a queue: while rsp_empty is low the oldest
//   result sits on rsp_out_byte, rsp_run_last and rsp_passthrough, and it is
//   taken at an edge with rsp_pop high. Registers are written through
//   csr_write_en, csr_index and csr_wdata: index 0 is enable (a write restarts
//   header detection), index 1 is the size limit.
//   Path: a byte taken at an edge is written into the entry queue and then loaded
//   into the output register, where its first result shows.
//   Throughput: one byte per cycle while req_full is low. A second header byte
//   makes two results; the output register drains one beat per cycle while
//   rsp_pop is high. The entry queue between front and back absorbs the extra
//   beat of two-result bytes. Reset clears the framing state and both queues and
//   loads enable = 1 and size limit = 8192. When rsp_pop stays low the output
//   register holds, the entry queue fills and req_full rises; nothing is dropped.
`default_nettype none

module record_prefix_to_line_break_filter_unit import rplb_pkg::*; #(
   parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_last,
   output logic             rsp_passthrough,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);

   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      q_full;
   logic      q_empty;
   logic      q_pop;
   logic      accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   rplb_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push_entry   (push_entry),
      .push         (push)
   );

   rplb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (head),
      .empty      (q_empty)
   );

   rplb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_passthrough (rsp_passthrough)
   );

endmodule

`default_nettype wire

// ===== rtl/rplb_front.sv =====
// Front end: accepts raw bytes, tracks record framing and classifies each byte.
// Holds the configuration registers. Depends on rplb_pkg.
`default_nettype none

module rplb_front import rplb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        accept,
   input  wire logic [7:0]  data_byte,
   input  wire logic        csr_write_en,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata,
   output entry_type        push_entry,
   output logic             push
);

   phase_type   phase_ff, phase_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic        pad_pending_ff, pad_pending_in;
   logic [7:0]  held_ff, held_in;
   logic        enable_ff;
   logic [15:0] size_limit_ff;
   logic [15:0] size;
   logic        bad;
   logic        has_result;

   assign size = {data_byte, held_ff};
   assign bad  = (size >= size_limit_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b1;
         size_limit_ff <= SIZE_LIMIT_RST;
      end else if (csr_write_en) begin
         if (csr_index == CSR_ENABLE) begin
            enable_ff <= csr_wdata[0];
         end else begin
            size_limit_ff <= csr_wdata;
         end
      end
   end

   // next state
   always_comb begin
      phase_in       = phase_ff;
      bytes_left_in  = bytes_left_ff;
      pad_pending_in = pad_pending_ff;
      held_in        = held_ff;
      priority if (csr_write_en && csr_index == CSR_ENABLE) begin
         phase_in       = PH_LOW;
         bytes_left_in  = '0;
         pad_pending_in = 1'b0;
         held_in        = '0;
      end else if (accept && enable_ff) begin
         unique case (phase_ff)
            PH_HIGH: begin
               if (bad) begin
                  phase_in = PH_PASS;
               end else begin
                  bytes_left_in  = size;
                  pad_pending_in = size[0];
                  phase_in       = (size != '0) ? PH_DATA : PH_LOW;
               end
            end
            PH_DATA: begin
               bytes_left_in = bytes_left_ff - 16'd1;
               if (bytes_left_ff == 16'd1) begin
                  phase_in = pad_pending_ff ? PH_PAD : PH_LOW;
               end
            end
            PH_PAD: begin
               pad_pending_in = 1'b0;
               phase_in       = PH_LOW;
            end
            PH_PASS: begin
               phase_in = PH_PASS;
            end
            default: begin
               held_in  = data_byte;
               phase_in = PH_HIGH;
            end
         endcase
      end
   end

   // classification
   always_comb begin
      has_result       = 1'b1;
      push_entry.two   = 1'b0;
      push_entry.byte0 = data_byte;
      push_entry.byte1 = data_byte;
      push_entry.pt    = (phase_ff == PH_PASS);
      if (enable_ff && phase_ff != PH_PASS) begin
         unique case (phase_ff)
            PH_HIGH: begin
               push_entry.two = 1'b1;
               if (bad) begin
                  push_entry.byte0 = held_ff;
                  push_entry.pt    = 1'b1;
               end else begin
                  push_entry.byte0 = CH_CR;
                  push_entry.byte1 = CH_LF;
               end
            end
            PH_DATA: push_entry.byte0 = data_byte;
            PH_PAD:  push_entry.byte0 = CH_SPACE;
            default: has_result = 1'b0;
         endcase
      end
   end

   assign push = accept && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LOW;
         bytes_left_ff  <= '0;
         pad_pending_ff <= 1'b0;
         held_ff        <= '0;
      end else begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         pad_pending_ff <= pad_pending_in;
         held_ff        <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rplb_queue.sv =====
// Short queue of classified entries between the front and back ends.
// Depends on rplb_pkg for the entry type.
`default_nettype none

module rplb_queue import rplb_pkg::*; #(
   parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  entry_type push_entry,
   output logic      full,
   input  wire logic pop,
   output entry_type head,
   output logic      empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   entry_type         mem [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

endmodule

`default_nettype wire

// ===== rtl/rplb_back.sv =====
// Back end: expands queue entries into one or two result beats.
// Holds the output register. Depends on rplb_pkg.
`default_nettype none

module rplb_back import rplb_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  entry_type  head,
   input  wire logic  q_empty,
   output logic       q_pop,
   output logic       rsp_empty,
   input  wire logic  rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_passthrough
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   logic       out_pt_ff, out_pt_in;
   logic       second_ff, second_in;
   logic       load;

   assign load = !out_valid_ff || rsp_pop;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_pop;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_pt_in    = out_pt_ff;
      second_in    = second_ff;
      q_pop        = 1'b0;
      if (load && !q_empty) begin
         out_valid_in = 1'b1;
         out_pt_in    = head.pt;
         if (second_ff) begin
            out_byte_in = head.byte1;
            out_last_in = 1'b1;
            second_in   = 1'b0;
            q_pop       = 1'b1;
         end else begin
            out_byte_in = head.byte0;
            out_last_in = !head.two;
            second_in   = head.two;
            q_pop       = !head.two;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_pt_ff   <= out_pt_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_run_last    = out_last_ff;
   assign rsp_passthrough = out_pt_ff;

   a_second_has_head: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> !q_empty)
      else $error("second half pending with empty queue");

   a_first_half_flag: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> second_ff)
      else $error("first beat of pair shown without second half pending");

endmodule

`default_nettype wire
